@@ sv/assert_macros.svh @@
// Assertion macros used by the port checker of the index pool allocator.
// Each macro samples on the rising edge of clock and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define IPA_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that ante at one edge implies cons at the same edge.
`define IPA_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ sv/ipa_pkg.sv @@
// Package for the index pool free list allocator: sizes, codes and types.
// Used by the top level, by its port checker and by the bench; depends on nothing.
`default_nettype none

package ipa_pkg;

   // Pool size and the widths that follow from it
   localparam int POOL_DEPTH = 1024;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
   localparam int SLOT_W     = 10;
   localparam int STATUS_W   = 2;
   localparam int CMP_W      = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD_W  = RSP_DATA_W - SLOT_W - STATUS_W;

   // Request kind carried on req_tuser
   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_NOT_LIVE = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   // Control sequencer states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

endpackage

`default_nettype wire

@@ sv/index_pool_free_list_allocator_top.sv @@
// Top level of the index pool free list allocator: LIFO free stack and live map
// kept in synchronous memories, with a read-modify-write sequencer. Uses ipa_pkg.
//
// Usage:
//   Request channel req_*: req_tuser selects the request (0 allocate, 1 free),
//   req_tdata[9:0] names the slot to free. Result channel rsp_*: one word per
//   request, rsp_tdata[9:0] the granted slot, rsp_tdata[11:10] the status
//   (0 done, 1 free ignored because slot not live, 2 pool full).
//   Allocate pops the most recently freed slot; with an empty stack it hands out
//   the next never-used slot from the high-water counter.
// Timing:
//   A request is accepted and its memory reads issue at that edge; the next cycle
//   decides, writes back and loads the result register, from which the result
//   word is then valid. A new request is taken only once the sequencer is back
//   in idle, after the memory read cycle and the write-back cycle of the stack
//   and live-map memories.
// Reset:
//   Synchronous active-high reset empties the stack and zeroes the high-water
//   counter. The memories are not cleared: live-map entries are used only below
//   the high-water mark and stack entries only below the stack count.
// Stall:
//   A result held by a low rsp_tready stays in its register; a new request is
//   accepted in the cycle the held word leaves, or at once if none is waiting.
`default_nettype none

module index_pool_free_list_allocator_top
   import ipa_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   // request channel
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [REQ_DATA_W-1:0]   req_tdata,   // [9:0] slot_to_free, [15:10] zero
   input  wire                    req_tuser,   // [0] mode
   // result channel
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata    // [9:0] granted_slot, [11:10] status,
                                               // [15:12] zero
);

   // Memories
   logic [IDX_W-1:0] stack_mem [POOL_DEPTH];
   logic             live_mem  [POOL_DEPTH];

   // Control and payload registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  hw_ff, hw_in;
   mode_type          mode_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [IDX_W-1:0]  stack_rd_ff;
   logic              live_rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   status_type        rsp_status_ff, rsp_status_in;

   // Memory access signals
   logic              req_accept;
   logic [IDX_W-1:0]  stack_raddr;
   logic [IDX_W-1:0]  live_raddr;
   logic [CMP_W-1:0]  req_slot_cmp;
   logic              stack_we;
   logic [IDX_W-1:0]  stack_waddr;
   logic [IDX_W-1:0]  stack_wdata;
   logic              live_we;
   logic [IDX_W-1:0]  live_waddr;
   logic              live_wdata;
   logic [CNT_W-1:0]  cnt_dec;
   logic [CMP_W-1:0]  slot_cmp;
   logic [CMP_W-1:0]  hw_cmp;
   logic [CMP_W-1:0]  grant_cmp;

   // Accept a word when idle and the result register is free or draining
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   // Read addresses: top of stack and the named slot
   assign cnt_dec      = cnt_ff - CNT_W'(1);
   assign stack_raddr  = cnt_dec[IDX_W-1:0];
   assign req_slot_cmp = CMP_W'(req_tdata[SLOT_W-1:0]);
   assign live_raddr   = req_slot_cmp[IDX_W-1:0];

   // Free stack memory
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stack_rd_ff <= stack_mem[stack_raddr];
      end
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
   end

   // Live map memory
   always_ff @(posedge clock) begin
      if (req_accept) begin
         live_rd_ff <= live_mem[live_raddr];
      end
      if (live_we) begin
         live_mem[live_waddr] <= live_wdata;
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= mode_type'(req_tuser);
         slot_ff <= req_tdata[SLOT_W-1:0];
      end
   end

   // Decide, write back and form the result
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      hw_in         = hw_ff;
      stack_we      = 1'b0;
      stack_waddr   = cnt_ff[IDX_W-1:0];
      slot_cmp      = CMP_W'(slot_ff);
      hw_cmp        = CMP_W'(hw_ff);
      stack_wdata   = slot_cmp[IDX_W-1:0];
      live_we       = 1'b0;
      live_waddr    = slot_cmp[IDX_W-1:0];
      live_wdata    = 1'b0;
      grant_cmp     = '0;
      rsp_status_in = ST_DONE;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (mode_ff == MODE_ALLOC) begin
               if (cnt_ff != '0) begin
                  // pop the most recently freed slot
                  cnt_in     = cnt_dec;
                  live_we    = 1'b1;
                  live_waddr = stack_rd_ff;
                  live_wdata = 1'b1;
                  grant_cmp  = CMP_W'(stack_rd_ff);
               end else if (hw_ff < CNT_W'(POOL_DEPTH)) begin
                  // hand out a fresh slot from the high-water counter
                  hw_in      = hw_ff + CNT_W'(1);
                  live_we    = 1'b1;
                  live_waddr = hw_ff[IDX_W-1:0];
                  live_wdata = 1'b1;
                  grant_cmp  = hw_cmp;
               end else begin
                  rsp_status_in = ST_FULL;
               end
            end else begin
               if ((slot_cmp >= hw_cmp) || !live_rd_ff) begin
                  rsp_status_in = ST_NOT_LIVE;
               end else begin
                  // clear the live bit and push the slot
                  live_we = 1'b1;
                  if (cnt_ff < CNT_W'(POOL_DEPTH)) begin
                     stack_we = 1'b1;
                     cnt_in   = cnt_ff + CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_slot_in = grant_cmp[SLOT_W-1:0];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register: load on the write-back cycle, hold otherwise
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_status_ff, rsp_slot_ff};

endmodule

`default_nettype wire

@@ sv/ipa_port_checker.sv @@
// Port checker for the index pool free list allocator, bound to the top level.
// Uses ipa_pkg and the macros of assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ipa_port_checker
   import ipa_pkg::*;
(
   input wire                    clock,
   input wire                    reset,
   input wire                    req_tvalid,
   input wire                    req_tready,
   input wire                    req_tuser,
   input wire                    rsp_tvalid,
   input wire                    rsp_tready,
   input wire [RSP_DATA_W-1:0]   rsp_tdata
);

   logic                req_acc;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_fail;
   logic                free_ok;
   logic                alloc_ok;
   logic                free_due;
   logic                alloc_due;
   logic                rsp_stall_ff;
   logic                req_acc_d1_ff;
   logic                req_acc_d2_ff;
   logic                req_free_d2_ff;
   logic                req_free_d1_ff;

   assign req_acc    = req_tvalid && req_tready;
   assign rsp_status = rsp_tdata[SLOT_W+STATUS_W-1:SLOT_W];
   assign rsp_slot   = rsp_tdata[SLOT_W-1:0];
   assign rsp_fail   = rsp_tvalid && (rsp_status != ST_DONE);
   assign free_ok    = rsp_status inside {ST_DONE, ST_NOT_LIVE};
   assign alloc_ok   = rsp_status inside {ST_DONE, ST_FULL};
   assign free_due   = req_acc_d2_ff && req_free_d2_ff;
   assign alloc_due  = req_acc_d2_ff && !req_free_d2_ff;

   // Track accepted requests through two delay registers and a stalled result word
   always_ff @(posedge clock) begin
      if (reset) begin
         req_acc_d1_ff <= 1'b0;
         req_acc_d2_ff <= 1'b0;
         rsp_stall_ff  <= 1'b0;
      end else begin
         req_acc_d1_ff <= req_acc;
         req_acc_d2_ff <= req_acc_d1_ff;
         rsp_stall_ff  <= rsp_tvalid && !rsp_tready;
      end
      req_free_d1_ff <= (req_tuser == MODE_FREE);
      req_free_d2_ff <= req_free_d1_ff;
   end

   // Hold a stalled result word
   `IPA_IMPLY(a_rsp_hold, rsp_stall_ff, rsp_tvalid, "result dropped while stalled")

   // Report no grant with a failing status
   `IPA_IMPLY(a_no_grant_on_fail, rsp_fail, rsp_slot == '0, "granted slot nonzero on failure")

   // Answer every request when its acceptance leaves the second delay register, with a status fit for its kind
   `IPA_IMPLY(a_free_result, free_due, rsp_tvalid && free_ok, "bad free result")

   `IPA_IMPLY(a_alloc_result, alloc_due, rsp_tvalid && alloc_ok, "bad allocate result")

   // Take no request while an unanswered one is in flight
   `IPA_ASSERT(a_one_in_flight, !(req_acc && req_acc_d1_ff), "overlapping requests")

endmodule

bind index_pool_free_list_allocator_top ipa_port_checker u_ipa_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking bench for index_pool_free_list_allocator_top: directed table, then random
// allocate/free traffic predicted by an in-bench free-list model. Depends on ipa_pkg.
`default_nettype none

module tb;
   import ipa_pkg::*;

   // One result word: granted slot and status
   typedef struct {
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } grant_type;

   // One directed stimulus row, with a hand-typed result where it is obvious
   typedef struct {
      mode_type          mode;
      logic [SLOT_W-1:0] slot;
      bit                typed;
      logic [SLOT_W-1:0] exp_slot;
      status_type        exp_status;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [9:0] slot_to_free, [15:10] zero
   logic                  req_tuser;   // [0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [9:0] granted_slot, [11:10] status, [15:12] zero

   // Free-list model state
   logic [SLOT_W-1:0] freed_slots [POOL_DEPTH];
   int                freed_count = 0;
   bit                live_slots[POOL_DEPTH];
   int                high_water_mark = 0;

   // Results still owed by the block, oldest first
   grant_type pending_grants[$];

   int errors        = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int full_grants   = 0;

   stim_row_type directed_rows [23] = '{
      // free on an empty pool, both ends of the slot range
      '{MODE_FREE,  10'd0,    1'b1, 10'd0, ST_NOT_LIVE},
      '{MODE_FREE,  10'd1023, 1'b1, 10'd0, ST_NOT_LIVE},
      // fresh slots from the high-water counter; slot field is don't-care
      '{MODE_ALLOC, 10'd1023, 1'b1, 10'd0, ST_DONE},
      '{MODE_ALLOC, 10'd0,    1'b1, 10'd1, ST_DONE},
      '{MODE_ALLOC, 10'd682,  1'b1, 10'd2, ST_DONE},
      // free, then double free
      '{MODE_FREE,  10'd1,    1'b1, 10'd0, ST_DONE},
      '{MODE_FREE,  10'd1,    1'b1, 10'd0, ST_NOT_LIVE},
      // pop the freed slot
      '{MODE_ALLOC, 10'd341,  1'b1, 10'd1, ST_DONE},
      // last freed comes back first
      '{MODE_FREE,  10'd0,    1'b1, 10'd0, ST_DONE},
      '{MODE_FREE,  10'd2,    1'b1, 10'd0, ST_DONE},
      '{MODE_ALLOC, 10'd0,    1'b1, 10'd2, ST_DONE},
      '{MODE_ALLOC, 10'd0,    1'b1, 10'd0, ST_DONE},
      // free exactly at and far above the high-water mark
      '{MODE_FREE,  10'd3,    1'b1, 10'd0, ST_NOT_LIVE},
      '{MODE_ALLOC, 10'd1023, 1'b1, 10'd3, ST_DONE},
      '{MODE_FREE,  10'd682,  1'b1, 10'd0, ST_NOT_LIVE},
      '{MODE_FREE,  10'd341,  1'b1, 10'd0, ST_NOT_LIVE},
      '{MODE_FREE,  10'd3,    1'b1, 10'd0, ST_DONE},
      // deeper stack, left to the predictor
      '{MODE_FREE,  10'd0,    1'b0, 10'd0, ST_DONE},
      '{MODE_FREE,  10'd2,    1'b0, 10'd0, ST_DONE},
      '{MODE_ALLOC, 10'd512,  1'b0, 10'd0, ST_DONE},
      '{MODE_ALLOC, 10'd511,  1'b0, 10'd0, ST_DONE},
      '{MODE_ALLOC, 10'd0,    1'b0, 10'd0, ST_DONE},
      '{MODE_ALLOC, 10'd1023, 1'b0, 10'd0, ST_DONE}
   };

   index_pool_free_list_allocator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock, period 4
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Advance the free-list model by one request and return its result word
   function automatic grant_type predict_grant(input mode_type mode,
                                               input logic [SLOT_W-1:0] slot);
      grant_type g;
      g.slot   = '0;
      g.status = ST_DONE;
      if (mode == MODE_ALLOC) begin
         if (freed_count > 0) begin
            freed_count--;
            g.slot = freed_slots[freed_count];
            live_slots[g.slot] = 1'b1;
         end else if (high_water_mark < POOL_DEPTH) begin
            g.slot = SLOT_W'(high_water_mark);
            live_slots[high_water_mark] = 1'b1;
            high_water_mark++;
         end else begin
            g.status = ST_FULL;
         end
      end else if (int'(slot) >= high_water_mark || !live_slots[slot]) begin
         g.status = ST_NOT_LIVE;
      end else begin
         live_slots[slot] = 1'b0;
         if (freed_count < POOL_DEPTH) begin
            freed_slots[freed_count] = slot;
            freed_count++;
         end
      end
      return g;
   endfunction

   // Pick a slot that is most likely live, for a well-formed free
   function automatic logic [SLOT_W-1:0] pick_live_slot();
      logic [SLOT_W-1:0] slot;
      if (high_water_mark == 0)
         return '0;
      slot = SLOT_W'($urandom_range(high_water_mark - 1));
      for (int t = 0; t < 16 && !live_slots[slot]; t++)
         slot = SLOT_W'($urandom_range(high_water_mark - 1));
      return slot;
   endfunction

   // Offer one request word, hold it until taken, then log its expected result
   task automatic offer_request(input mode_type mode, input logic [SLOT_W-1:0] slot,
                                input bit typed, input grant_type typed_grant);
      grant_type g;
      while (!(words_sent >= 300 && words_sent < 500) && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_DATA_W'(slot);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      g = predict_grant(mode, slot);
      if (g.status == ST_FULL)
         full_grants++;
      pending_grants.insert(pending_grants.size(), typed ? typed_grant : g);
      words_sent++;
   endtask

   // One random request: allocate, noisy free, or free of a live slot
   task automatic offer_random(input int alloc_pct, input int noise_pct);
      int                r;
      logic [SLOT_W-1:0] slot;
      grant_type         unused;
      unused.slot   = '0;
      unused.status = ST_DONE;
      r    = $urandom_range(99);
      slot = SLOT_W'($urandom_range(1023));
      if (r < alloc_pct) begin
         offer_request(MODE_ALLOC, slot, 1'b0, unused);
      end else if (r < alloc_pct + noise_pct) begin
         // stale or double free below the mark, else any slot at all
         if (r[0] && high_water_mark > 0)
            slot = SLOT_W'($urandom_range(high_water_mark - 1));
         offer_request(MODE_FREE, slot, 1'b0, unused);
      end else begin
         offer_request(MODE_FREE, pick_live_slot(), 1'b0, unused);
      end
   endtask

   // Result side: check each word taken, stall at random, one long hold-off
   initial begin
      int        hold_left;
      bit        held;
      grant_type exp;
      hold_left = 0;
      held      = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            if (pending_grants.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word, expected none, actual slot %0d status %0d",
                        $time, rsp_tdata[SLOT_W-1:0], rsp_tdata[SLOT_W +: STATUS_W]);
            end else begin
               exp = pending_grants.pop_front();
               if (rsp_tdata[SLOT_W-1:0] !== exp.slot) begin
                  errors++;
                  $display("%0t: granted_slot mismatch, expected %0d, actual %0d",
                           $time, exp.slot, rsp_tdata[SLOT_W-1:0]);
               end
               if (rsp_tdata[SLOT_W +: STATUS_W] !== exp.status) begin
                  errors++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, exp.status, rsp_tdata[SLOT_W +: STATUS_W]);
               end
               words_checked++;
            end
         end
         // hold off once long enough for the block to back up its input
         if (!held && words_checked == 800) begin
            held      = 1'b1;
            hold_left = 200;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (words_checked >= 300 && words_checked < 500) ||
                          ($urandom_range(99) >= 8);
         end
      end
   end

   // Stimulus and end of run
   initial begin
      grant_type typed_g;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         typed_g.slot   = directed_rows[i].exp_slot;
         typed_g.status = directed_rows[i].exp_status;
         offer_request(directed_rows[i].mode, directed_rows[i].slot,
                       directed_rows[i].typed, typed_g);
      end

      // short mixed traffic, mostly well-formed
      for (int i = 0; i < 40; i++)
         offer_random(55, 10);
      // push the pool to exhaustion and keep knocking on it
      for (int i = 0; i < 1500 && full_grants < 12; i++)
         offer_random(98, 1);
      // free back into the stack and pop again
      for (int i = 0; i < 40; i++)
         offer_random(30, 10);

      req_tvalid <= 1'b0;
      while (pending_grants.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0 && pending_grants.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
